[hw/rtl/f2s_pkg.sv]
// shared types and constants for the two-stack queue
`default_nettype none

package f2s_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // request codes
  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    RES_PUT_OK,
    RES_OVERFLOW,
    RES_UNDERFLOW,
    RES_GOT
  } res_kind_e;

  typedef struct packed {
    logic      push;
    logic      pop_rd;
    logic      xfer_rd;
    logic      load_res;
    res_kind_e res_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic entry_full;
    logic entry_zero;
    logic exit_zero;
    logic mv_pending;
    logic slot_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/fifo_from_two_stacks.sv]
// top level of the first-in first-out queue built from two stacks
`default_nettype none

// Queue of up to 2*STACK_DEPTH values held in two stacks of STACK_DEPTH
// entries each. Every input transaction is a put (req_type 0) or a get
// (req_type 1) and yields exactly one result transaction carrying the removed
// value (zero unless a get succeeds), a status (ok, overflow when the entry
// stack is full even if the exit stack has room, underflow on an empty queue)
// and the empty flag after the operation. One transaction is in flight at a
// time. A put, an overflowing put and an underflowing get finish in the
// accept cycle; a get served from a non-empty exit stack waits in S_GET
// for the registered read of the exit stack ram; a get that finds the
// exit stack empty first moves all n entries of the entry stack across, one
// per cycle through the entry ram read port, then reads the exit stack. A
// new transaction is taken once the fsm is back in idle after the result
// is loaded and the result register is free or being emptied. No clearing
// pass is needed after reset: the stack counts alone say what is valid.

module fifo_from_two_stacks #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               req_type_i,
  input  wire logic signed [f2s_pkg::ValueW-1:0]  put_value_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed      [f2s_pkg::ValueW-1:0]  got_value_o,
  output logic             [f2s_pkg::StatusW-1:0] status_o,
  output logic                                    queue_empty_o
);

  // commands from the fsm, status back from the datapath
  f2s_pkg::ctrl_cmd_t cmd;
  f2s_pkg::dp_stat_t  stat;

  f2s_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stacks, counts and the output register live here
  f2s_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .put_value_i   (put_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .got_value_o   (got_value_o),
    .status_o      (status_o),
    .queue_empty_o (queue_empty_o)
  );

endmodule

`default_nettype wire

[hw/rtl/f2s_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module f2s_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/f2s_ctrl.sv]
// sequencing fsm for the two-stack queue
`default_nettype none

module f2s_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              req_type_i,
  input  wire f2s_pkg::dp_stat_t stat_i,
  output f2s_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_XFER = 2'd1;
  localparam logic [1:0] S_GET  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res_kind = f2s_pkg::RES_PUT_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == f2s_pkg::REQ_PUT) begin
            cmd_o.load_res = 1'b1;
            if (stat_i.entry_full) begin
              cmd_o.res_kind = f2s_pkg::RES_OVERFLOW;
            end else begin
              cmd_o.push     = 1'b1;
              cmd_o.res_kind = f2s_pkg::RES_PUT_OK;
            end
          end else if (stat_i.exit_zero && stat_i.entry_zero) begin
            cmd_o.load_res = 1'b1;
            cmd_o.res_kind = f2s_pkg::RES_UNDERFLOW;
          end else if (stat_i.exit_zero) begin
            state_d = S_XFER;
          end else begin
            cmd_o.pop_rd = 1'b1;
            state_d      = S_GET;
          end
        end
      end
      S_XFER: begin
        // drain entry stack, then wait for the last move write to land
        if (!stat_i.entry_zero) begin
          cmd_o.xfer_rd = 1'b1;
        end else if (!stat_i.mv_pending) begin
          cmd_o.pop_rd = 1'b1;
          state_d      = S_GET;
        end
      end
      S_GET: begin
        cmd_o.load_res = 1'b1;
        cmd_o.res_kind = f2s_pkg::RES_GOT;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/f2s_dp.sv]
// datapath: both stacks, their counts and the result register
`default_nettype none

module f2s_dp #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire f2s_pkg::ctrl_cmd_t                  cmd_i,
  output f2s_pkg::dp_stat_t                        stat_o,
  input  wire logic signed [f2s_pkg::ValueW-1:0]   put_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [f2s_pkg::ValueW-1:0]   got_value_o,
  output logic             [f2s_pkg::StatusW-1:0]  status_o,
  output logic                                     queue_empty_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [CntW-1:0]       entry_cnt_q, entry_cnt_d, exit_cnt_q, exit_cnt_d;
  logic [CntW-1:0]       entry_dec, exit_dec;
  logic                  mv_q;
  logic [63:0]           put_ext, rd_ext;
  logic [DATA_WIDTH-1:0] entry_wdata, entry_rdata, exit_rdata;
  logic                  out_valid_q;
  logic [f2s_pkg::ValueW-1:0]  got_q, got_d;
  logic [f2s_pkg::StatusW-1:0] status_q, status_d;
  logic                  empty_q;

  assign entry_dec   = entry_cnt_q - CntW'(1);
  assign exit_dec    = exit_cnt_q - CntW'(1);
  assign put_ext     = 64'($unsigned(put_value_i));
  assign entry_wdata = put_ext[DATA_WIDTH-1:0];
  assign rd_ext      = 64'(exit_rdata);

  f2s_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (entry_cnt_q[AddrW-1:0]),
    .wdata_i (entry_wdata),
    .re_i    (cmd_i.xfer_rd),
    .raddr_i (entry_dec[AddrW-1:0]),
    .rdata_o (entry_rdata)
  );

  f2s_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_exit_ram (
    .clk_i   (clk_i),
    .we_i    (mv_q),
    .waddr_i (exit_cnt_q[AddrW-1:0]),
    .wdata_i (entry_rdata),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (exit_dec[AddrW-1:0]),
    .rdata_o (exit_rdata)
  );

  always_comb begin
    entry_cnt_d = entry_cnt_q;
    exit_cnt_d  = exit_cnt_q;
    if (cmd_i.push) begin
      entry_cnt_d = entry_cnt_q + CntW'(1);
    end else if (cmd_i.xfer_rd) begin
      entry_cnt_d = entry_dec;
    end
    if (mv_q) begin
      exit_cnt_d = exit_cnt_q + CntW'(1);
    end else if (cmd_i.pop_rd) begin
      exit_cnt_d = exit_dec;
    end
  end

  always_comb begin
    got_d    = '0;
    status_d = f2s_pkg::ST_OK;
    case (cmd_i.res_kind)
      f2s_pkg::RES_PUT_OK:    status_d = f2s_pkg::ST_OK;
      f2s_pkg::RES_OVERFLOW:  status_d = f2s_pkg::ST_OVERFLOW;
      f2s_pkg::RES_UNDERFLOW: status_d = f2s_pkg::ST_UNDERFLOW;
      f2s_pkg::RES_GOT:       got_d    = rd_ext[f2s_pkg::ValueW-1:0];
      default:                status_d = f2s_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
      exit_cnt_q  <= '0;
      mv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      entry_cnt_q <= entry_cnt_d;
      exit_cnt_q  <= exit_cnt_d;
      mv_q        <= cmd_i.xfer_rd;
      if (cmd_i.load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      got_q    <= got_d;
      status_q <= status_d;
      empty_q  <= (entry_cnt_d == '0) && (exit_cnt_d == '0);
    end
  end

  assign stat_o.entry_full = (entry_cnt_q == CntW'(STACK_DEPTH));
  assign stat_o.entry_zero = (entry_cnt_q == '0);
  assign stat_o.exit_zero  = (exit_cnt_q == '0);
  assign stat_o.mv_pending = mv_q;
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign got_value_o   = $signed(got_q);
  assign status_o      = status_q;
  assign queue_empty_o = empty_q;

endmodule

`default_nettype wire

[test/tb_fifo_from_two_stacks.sv]
// testbench for the two-stack queue: directed table, then random put/get phases
`default_nettype none

module tb_fifo_from_two_stacks;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = 16;
  localparam int unsigned NumRandom  = 1900;
  localparam int unsigned MaxWait    = 15;
  // covers the longest transfer, of Depth entries, and the result hand-off
  localparam int unsigned TailCycles = Depth + 8;
  // cycles with no transaction on either side before the run is abandoned
  localparam int unsigned StallLimit = 2000;

  // one result transaction as the queue should present it
  typedef struct packed {
    logic signed [f2s_pkg::ValueW-1:0]  value;
    logic        [f2s_pkg::StatusW-1:0] status;
    logic                               is_empty;
  } outcome_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    logic                              req;
    logic signed [f2s_pkg::ValueW-1:0] value;
    bit                                typed;
    outcome_t                          want;
  } stim_row_t;

  // every input is known from time zero
  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               req_type_i  = f2s_pkg::REQ_PUT;
  logic signed [f2s_pkg::ValueW-1:0]  put_value_i = '0;
  logic                               out_ready_i = 1'b0;
  logic                               in_ready_o;
  logic                               out_valid_o;
  logic signed [f2s_pkg::ValueW-1:0]  got_value_o;
  logic        [f2s_pkg::StatusW-1:0] status_o;
  logic                               queue_empty_o;

  // shadow copy of the two stacks
  logic signed [f2s_pkg::ValueW-1:0] entry_mem [Depth];
  logic signed [f2s_pkg::ValueW-1:0] exit_mem  [Depth];
  int unsigned                       entry_cnt = 0;
  int unsigned                       exit_cnt  = 0;

  outcome_t    outcome_q [$];   // results owed by the queue, oldest first
  stim_row_t   directed_rows [$];
  bit          cur_typed = 1'b0;
  outcome_t    cur_want  = '0;
  bit          no_idle   = 1'b0; // set for stretches where neither side idles
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  fifo_from_two_stacks #(
    .STACK_DEPTH (Depth),
    .DATA_WIDTH  (f2s_pkg::ValueW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .put_value_i   (put_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .got_value_o   (got_value_o),
    .status_o      (status_o),
    .queue_empty_o (queue_empty_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // apply one put or get to the shadow stacks and work out the result
  function automatic outcome_t apply_queue_op(input logic req,
                                              input logic signed [f2s_pkg::ValueW-1:0] v);
    outcome_t r;
    r = '0;
    r.status = f2s_pkg::ST_OK;
    if (req == f2s_pkg::REQ_PUT) begin
      // a full entry stack refuses the put even when the exit stack has room
      if (entry_cnt >= Depth) begin
        r.status = f2s_pkg::ST_OVERFLOW;
      end else begin
        entry_mem[entry_cnt] = v;
        entry_cnt++;
      end
    end else if (entry_cnt == 0 && exit_cnt == 0) begin
      r.status = f2s_pkg::ST_UNDERFLOW;
    end else begin
      // empty exit stack: tip the whole entry stack over, top first
      if (exit_cnt == 0) begin
        while (entry_cnt > 0) begin
          entry_cnt--;
          exit_mem[exit_cnt] = entry_mem[entry_cnt];
          exit_cnt++;
        end
      end
      exit_cnt--;
      r.value = exit_mem[exit_cnt];
    end
    r.is_empty = (entry_cnt == 0 && exit_cnt == 0);
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // mostly full-width random values, now and then an extreme
  function automatic logic signed [f2s_pkg::ValueW-1:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic outcome_t mk_outcome(input logic signed [f2s_pkg::ValueW-1:0] v,
                                          input logic [f2s_pkg::StatusW-1:0] st,
                                          input logic e);
    outcome_t r;
    r.value    = v;
    r.status   = st;
    r.is_empty = e;
    return r;
  endfunction

  task automatic add_row(input logic req, input logic signed [f2s_pkg::ValueW-1:0] v,
                         input bit typed, input outcome_t want);
    stim_row_t row;
    row.req   = req;
    row.value = v;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // present one request transaction; entered and left at a falling edge
  task automatic send_request(input logic req, input logic signed [f2s_pkg::ValueW-1:0] v,
                              input bit typed, input outcome_t want);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    put_value_i <= v;
    cur_typed   = typed;
    cur_want    = want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // result side: ready drops for a freshly drawn number of cycles, possibly zero, before each result
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // result check first: a result never belongs to a request taken on the same edge
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result transaction with none outstanding: value %0d status %0d",
                 got_value_o, status_o);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (got_value_o !== want.value) begin
            $error("got_value: expected %0d, got %0d", want.value, got_value_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_count++;
          end
          if (queue_empty_o !== want.is_empty) begin
            $error("queue_empty: expected %0d, got %0d", want.is_empty, queue_empty_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        // the shadow stacks move on every request, typed row or not
        want = apply_queue_op(req_type_i, put_value_i);
        if (cur_typed) want = cur_want;
        outcome_q.push_back(want);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("tb_fifo_from_two_stacks: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned put_pct;
    logic        req;

    // directed table: underflow at reset, extremes, a fill that overflows while
    // the exit stack still has room, then gets served from the reversed entries
    add_row(f2s_pkg::REQ_GET, '0, 1'b1, mk_outcome('0, f2s_pkg::ST_UNDERFLOW, 1'b1));
    add_row(f2s_pkg::REQ_PUT, 32'sh7FFF_FFFF, 1'b1, mk_outcome('0, f2s_pkg::ST_OK, 1'b0));
    add_row(f2s_pkg::REQ_PUT, 32'sh8000_0000, 1'b1, mk_outcome('0, f2s_pkg::ST_OK, 1'b0));
    add_row(f2s_pkg::REQ_PUT, '0, 1'b0, '0);
    add_row(f2s_pkg::REQ_PUT, '1, 1'b0, '0);
    // first get moves all four across and hands back the oldest
    add_row(f2s_pkg::REQ_GET, '0, 1'b1,
            mk_outcome(32'sh7FFF_FFFF, f2s_pkg::ST_OK, 1'b0));
    for (int i = 0; i < Depth; i++) begin
      add_row(f2s_pkg::REQ_PUT, (i % 2) ? (32'sh1 << i) : ~(32'sh1 << (i + 16)),
              1'b0, '0);
    end
    add_row(f2s_pkg::REQ_PUT, 32'sh5A5A_A5A5, 1'b1,
            mk_outcome('0, f2s_pkg::ST_OVERFLOW, 1'b0));
    add_row(f2s_pkg::REQ_GET, '0, 1'b1,
            mk_outcome(32'sh8000_0000, f2s_pkg::ST_OK, 1'b0));
    add_row(f2s_pkg::REQ_GET, '0, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases: put-heavy runs fill to overflow, get-heavy runs drain
    // through transfers into underflow, balanced runs keep both stacks busy
    sent  = 0;
    phase = 0;
    while (sent < NumRandom) begin
      case ($urandom_range(0, 2))
        0:       put_pct = 80;
        1:       put_pct = 20;
        default: put_pct = 50;
      endcase
      phase_len = $urandom_range(40, 120);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        req = ($urandom_range(0, 99) < put_pct) ? f2s_pkg::REQ_PUT : f2s_pkg::REQ_GET;
        send_request(req, draw_value(), 1'b0, '0);
        sent++;
      end
      // every fourth phase the sender holds off until the queue has answered all
      if (phase % 4 == 0) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (outcome_q.size() != 0) @(negedge clk_i);
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    no_idle    = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_fifo_from_two_stacks: done, clean");
    end else begin
      $display("tb_fifo_from_two_stacks: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
